[design/tfb_pkg.sv]
`default_nettype none
package tfb_pkg;

	// default number of channel slots
	localparam int MAX_CHANNELS_DEF = 8;

	// crc16-ccitt constants
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// configuration register indexes
	localparam logic [1:0] REG_SEND_DIVIDER      = 2'd0;
	localparam logic [1:0] REG_CHANNEL_COUNT     = 2'd1;
	localparam logic [1:0] REG_START_BYTE_FIRST  = 2'd2;
	localparam logic [1:0] REG_START_BYTE_SECOND = 2'd3;

	// input action codes
	localparam logic ACT_STORE = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	// one byte through the msb-first crc16 shift register
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[design/telemetry_frame_builder_crc16_top.sv]
`default_nettype none
// channel  signals                                       direction
// input    in_valid/in_ready, action, channel_index,     in
//          sample_bits
// output   out_valid/out_ready, frame_byte, last_byte    out
// config   cfg_valid/cfg_ready, cfg_index, cfg_data      in
//
// a store item or a tick that does not send leaves in_ready high
// a sending tick with a nonzero channel count emits 10 + 4n frame bytes,
// one per cycle through the crc byte unit while out_ready does not stall
// in_ready stays low until the last frame byte sits in the output register
// arst_n clears the counters, the sample registers and the configuration (send divider resets to 1)
module telemetry_frame_builder_crc16_top
	import tfb_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [2:0]  channel_index,
	input  wire logic [31:0] sample_bits,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       frame_byte,
	output logic             last_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int POS_W = $clog2(12 + 4 * MAX_CHANNELS + 1);

	// header byte positions
	localparam logic [POS_W-1:0] POS_SOF0  = POS_W'(0);
	localparam logic [POS_W-1:0] POS_SOF1  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LEN_L = POS_W'(2);
	localparam logic [POS_W-1:0] POS_LEN_H = POS_W'(3);
	localparam logic [POS_W-1:0] POS_SEQ_L = POS_W'(4);
	localparam logic [POS_W-1:0] POS_SEQ_H = POS_W'(5);
	localparam logic [POS_W-1:0] POS_CNT_L = POS_W'(6);
	localparam logic [POS_W-1:0] POS_CNT_H = POS_W'(7);
	localparam logic [POS_W-1:0] POS_DATA  = POS_W'(8);

	// sequencer states
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SEND = 1'b1;

	logic              state_q;
	logic [POS_W-1:0]  pos_q;
	logic [15:0]       tick_count_q;
	logic [15:0]       frame_sequence_q;
	logic [15:0]       crc_q;
	logic [31:0]       samples_q [MAX_CHANNELS];
	logic [15:0]       send_divider_q;
	logic [3:0]        channel_count_q;
	logic [7:0]        sof_first_q;
	logic [7:0]        sof_second_q;
	logic              out_valid_q;
	logic [7:0]        frame_byte_q;
	logic              last_byte_q;

	logic              in_fire;
	logic              cfg_fire;
	logic [15:0]       div_eff;
	logic [15:0]       tick_next;
	logic              tick_sends;
	logic [3:0]        n_sat;
	logic [15:0]       total_len;
	logic [POS_W-1:0]  crc_lo_pos;
	logic [POS_W-1:0]  last_pos;
	logic [POS_W-1:0]  data_off;
	logic [CH_W-1:0]   rd_ch;
	logic [31:0]       rd_sample;
	logic [7:0]        next_byte;
	logic              advance;
	logic              is_last;
	logic              is_crc;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign cfg_fire  = cfg_valid && cfg_ready;

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign last_byte  = last_byte_q;

	// decimation compare and saturated channel count
	assign div_eff    = (send_divider_q == 16'd0) ? 16'd1 : send_divider_q;
	assign tick_next  = tick_count_q + 16'd1;
	assign tick_sends = (tick_next >= div_eff);
	assign n_sat      = (32'(channel_count_q) > MAX_CHANNELS) ? 4'(MAX_CHANNELS)
	                                                          : channel_count_q;
	assign total_len  = 16'({n_sat, 2'b00}) + 16'd10;
	assign crc_lo_pos = POS_DATA + POS_W'({n_sat, 2'b00});
	assign last_pos   = crc_lo_pos + POS_W'(1);

	// sample byte lookup
	assign data_off  = pos_q - POS_DATA;
	assign rd_ch     = CH_W'(data_off >> 2);
	assign rd_sample = samples_q[rd_ch];

	assign is_last = (pos_q == last_pos);
	assign is_crc  = (pos_q == crc_lo_pos) || is_last;
	assign advance = (state_q == ST_SEND) && (!out_valid_q || out_ready);

	// frame byte select
	always_comb begin
		next_byte = 8'h00;
		case (pos_q)
			POS_SOF0:  next_byte = sof_first_q;
			POS_SOF1:  next_byte = sof_second_q;
			POS_LEN_L: next_byte = total_len[7:0];
			POS_LEN_H: next_byte = total_len[15:8];
			POS_SEQ_L: next_byte = frame_sequence_q[7:0];
			POS_SEQ_H: next_byte = frame_sequence_q[15:8];
			POS_CNT_L: next_byte = 8'(n_sat);
			POS_CNT_H: next_byte = 8'h00;
			default: begin
				if (is_last) begin
					next_byte = crc_q[15:8];
				end else if (pos_q == crc_lo_pos) begin
					next_byte = crc_q[7:0];
				end else begin
					case (data_off[1:0])
						2'd0:    next_byte = rd_sample[7:0];
						2'd1:    next_byte = rd_sample[15:8];
						2'd2:    next_byte = rd_sample[23:16];
						default: next_byte = rd_sample[31:24];
					endcase
				end
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_divider_q  <= 16'd1;
			channel_count_q <= 4'd0;
			sof_first_q     <= 8'h00;
			sof_second_q    <= 8'h00;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_SEND_DIVIDER:      send_divider_q  <= cfg_data;
				REG_CHANNEL_COUNT:     channel_count_q <= cfg_data[3:0];
				REG_START_BYTE_FIRST:  sof_first_q     <= cfg_data[7:0];
				REG_START_BYTE_SECOND: sof_second_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// per-channel sample registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				samples_q[i] <= 32'd0;
			end
		end else if (in_fire && action == ACT_STORE && 32'(channel_index) < MAX_CHANNELS) begin
			samples_q[CH_W'(channel_index)] <= sample_bits;
		end
	end

	// sequencer, tick counter and crc unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			pos_q            <= '0;
			tick_count_q     <= 16'd0;
			frame_sequence_q <= 16'd0;
			crc_q            <= CRC_INIT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && action == ACT_TICK) begin
						if (tick_sends) begin
							tick_count_q <= 16'd0;
							if (n_sat != 4'd0) begin
								state_q <= ST_SEND;
								pos_q   <= '0;
								crc_q   <= CRC_INIT;
							end
						end else begin
							tick_count_q <= tick_next;
						end
					end
				end
				ST_SEND: begin
					if (advance) begin
						if (!is_crc) begin
							crc_q <= crc16_byte(crc_q, next_byte);
						end
						if (is_last) begin
							state_q          <= ST_IDLE;
							frame_sequence_q <= frame_sequence_q + 16'd1;
						end else begin
							pos_q <= pos_q + POS_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_byte_q <= next_byte;
			last_byte_q  <= is_last;
		end
	end

	// the byte position never runs past the final crc byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND) |-> (pos_q <= last_pos))
		else $error("byte position past end of frame");

	// each finished frame bumps the sequence number by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_last) |=> (frame_sequence_q == $past(frame_sequence_q) + 16'd1))
		else $error("sequence number not advanced after frame");

	// a sending tick with channels configured starts a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && action == ACT_TICK && tick_sends && n_sat != 4'd0)
		|=> (state_q == ST_SEND && pos_q == POS_SOF0))
		else $error("sending tick did not start a frame");

	// the last byte of a frame goes out with valid and the last flag, with the sequencer back in idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_last) |=> (out_valid_q && last_byte_q && state_q == ST_IDLE))
		else $error("last byte not presented at end of frame");

endmodule
`default_nettype wire

[dv/telemetry_frame_builder_crc16_top_test.sv]
`timescale 1ns / 100ps

module telemetry_frame_builder_crc16_top_test
	import tfb_pkg::*;
;

	localparam int SLOTS          = MAX_CHANNELS_DEF;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 400;
	localparam int N_DIRECTED     = 31;
	localparam int N_PHASES       = 8;
	localparam int PHASE_ITEMS    = 14;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	typedef enum logic [1:0] {ROW_ITEM, ROW_QUIET, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        act;
		logic [2:0]  idx;
		logic [1:0]  sel;
		logic [31:0] val;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [2:0]  channel_index;
	logic [31:0] sample_bits;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  frame_byte;
	logic        last_byte;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// shadow copy of the block's registers and state
	logic [15:0] div_cfg;
	logic [3:0]  count_cfg;
	logic [7:0]  sof_first;
	logic [7:0]  sof_second;
	logic [15:0] tick_total;
	logic [15:0] seq_no;
	logic [31:0] samples [SLOTS];

	frame_byte_t frame_bytes_due [$];
	int unsigned byte_errors = 0;
	int unsigned bytes_seen  = 0;
	int unsigned idle_cycles = 0;
	bit          no_gaps     = 1'b0;

	// zero channel tick after reset, extreme samples, saturated count,
	// divider of zero, divider lowered below the count, widest divider
	step_t directed [N_DIRECTED] = '{
		'{ROW_QUIET, ACT_TICK,  3'd0, REG_SEND_DIVIDER,      32'h0000_0000},
		'{ROW_QUIET, ACT_STORE, 3'd0, REG_SEND_DIVIDER,      32'hFFFF_FFFF},
		'{ROW_QUIET, ACT_STORE, 3'd7, REG_SEND_DIVIDER,      32'h0000_0000},
		'{ROW_QUIET, ACT_STORE, 3'd3, REG_SEND_DIVIDER,      32'h3F80_0000},
		'{ROW_QUIET, ACT_STORE, 3'd5, REG_SEND_DIVIDER,      32'h8000_0001},
		'{ROW_REG,   ACT_STORE, 3'd0, REG_CHANNEL_COUNT,     32'd8},
		'{ROW_REG,   ACT_STORE, 3'd0, REG_START_BYTE_FIRST,  32'hAA},
		'{ROW_REG,   ACT_STORE, 3'd0, REG_START_BYTE_SECOND, 32'h55},
		'{ROW_ITEM,  ACT_TICK,  3'd0, REG_SEND_DIVIDER,      32'h0000_0000},
		'{ROW_REG,   ACT_STORE, 3'd0, REG_CHANNEL_COUNT,     32'd15},
		'{ROW_REG,   ACT_STORE, 3'd0, REG_START_BYTE_FIRST,  32'hFF},
		'{ROW_REG,   ACT_STORE, 3'd0, REG_START_BYTE_SECOND, 32'h00},
		'{ROW_ITEM,  ACT_TICK,  3'd6, REG_SEND_DIVIDER,      32'hDEAD_BEEF},
		'{ROW_REG,   ACT_STORE, 3'd0, REG_SEND_DIVIDER,      32'd0},
		'{ROW_REG,   ACT_STORE, 3'd0, REG_CHANNEL_COUNT,     32'd1},
		'{ROW_ITEM,  ACT_TICK,  3'd0, REG_SEND_DIVIDER,      32'h0000_0000},
		'{ROW_QUIET, ACT_STORE, 3'd0, REG_SEND_DIVIDER,      32'h1234_5678},
		'{ROW_ITEM,  ACT_TICK,  3'd0, REG_SEND_DIVIDER,      32'h0000_0000},
		'{ROW_REG,   ACT_STORE, 3'd0, REG_SEND_DIVIDER,      32'd3},
		'{ROW_QUIET, ACT_TICK,  3'd0, REG_SEND_DIVIDER,      32'h0000_0000},
		'{ROW_QUIET, ACT_TICK,  3'd0, REG_SEND_DIVIDER,      32'h0000_0000},
		'{ROW_ITEM,  ACT_TICK,  3'd0, REG_SEND_DIVIDER,      32'h0000_0000},
		'{ROW_QUIET, ACT_TICK,  3'd0, REG_SEND_DIVIDER,      32'h0000_0000},
		'{ROW_QUIET, ACT_TICK,  3'd0, REG_SEND_DIVIDER,      32'h0000_0000},
		'{ROW_REG,   ACT_STORE, 3'd0, REG_SEND_DIVIDER,      32'd1},
		'{ROW_ITEM,  ACT_TICK,  3'd0, REG_SEND_DIVIDER,      32'h0000_0000},
		'{ROW_REG,   ACT_STORE, 3'd0, REG_SEND_DIVIDER,      32'hFFFF},
		'{ROW_QUIET, ACT_TICK,  3'd0, REG_SEND_DIVIDER,      32'h0000_0000},
		'{ROW_REG,   ACT_STORE, 3'd0, REG_CHANNEL_COUNT,     32'd0},
		'{ROW_REG,   ACT_STORE, 3'd0, REG_SEND_DIVIDER,      32'd2},
		'{ROW_QUIET, ACT_TICK,  3'd0, REG_SEND_DIVIDER,      32'h0000_0000}
	};

	telemetry_frame_builder_crc16_top #(
		.MAX_CHANNELS(SLOTS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.channel_index(channel_index),
		.sample_bits  (sample_bits),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_byte   (frame_byte),
		.last_byte    (last_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// msb-first crc16 over one byte
	function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {b, 8'h00};
		repeat (8) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	// update the shadow state for one item and queue the frame it sends
	task automatic frame_after_item(input logic act, input logic [2:0] idx,
			input logic [31:0] smp, input bit keep);
		logic [15:0] limit;
		logic [15:0] n;
		logic [15:0] total;
		logic [15:0] crc;
		logic [7:0]  body [$];
		if (act == ACT_STORE) begin
			if (idx < SLOTS) samples[idx] = smp;
			return;
		end
		limit = (div_cfg == 16'd0) ? 16'd1 : div_cfg;
		tick_total = tick_total + 16'd1;
		if (tick_total < limit) return;
		tick_total = 16'd0;
		n = (count_cfg > SLOTS) ? 16'(SLOTS) : 16'(count_cfg);
		if (n == 16'd0) return;
		total = 16'd10 + 16'd4 * n;
		body = {sof_first, sof_second, total[7:0], total[15:8],
			seq_no[7:0], seq_no[15:8], n[7:0], n[15:8]};
		seq_no = seq_no + 16'd1;
		for (int c = 0; c < n; c++) begin
			body.push_back(samples[c][7:0]);
			body.push_back(samples[c][15:8]);
			body.push_back(samples[c][23:16]);
			body.push_back(samples[c][31:24]);
		end
		crc = CRC_INIT;
		foreach (body[i]) crc = crc_step(crc, body[i]);
		if (!keep) return;
		foreach (body[i]) frame_bytes_due.push_back('{body[i], 1'b0});
		frame_bytes_due.push_back('{crc[7:0], 1'b0});
		frame_bytes_due.push_back('{crc[15:8], 1'b1});
	endtask

	// one item on the input channel, with a random gap ahead of it
	task automatic send_item(input logic act, input logic [2:0] idx,
			input logic [31:0] smp, input bit keep);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		channel_index <= idx;
		sample_bits   <= smp;
		do @(posedge clk); while (!in_ready);
		frame_after_item(act, idx, smp, keep);
	endtask

	// wait until every queued frame byte is out and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frame_bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write, mirrored into the shadow copy
	task automatic write_reg(input logic [1:0] sel, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (sel)
			REG_SEND_DIVIDER:      div_cfg    = data;
			REG_CHANNEL_COUNT:     count_cfg  = data[3:0];
			REG_START_BYTE_FIRST:  sof_first  = data[7:0];
			REG_START_BYTE_SECOND: sof_second = data[7:0];
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// main sequence
	initial begin
		logic        act;
		logic [2:0]  idx;
		logic [31:0] smp;
		logic [15:0] divv;
		logic [15:0] cnt;
		div_cfg    = 16'd1;
		count_cfg  = 4'd0;
		sof_first  = 8'h00;
		sof_second = 8'h00;
		tick_total = 16'd0;
		seq_no     = 16'd0;
		foreach (samples[i]) samples[i] = 32'd0;

		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		action        <= ACT_STORE;
		channel_index <= 3'd0;
		sample_bits   <= 32'd0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_SEND_DIVIDER;
		cfg_data      <= 16'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_DIRECTED; i++) begin
			case (directed[i].kind)
				ROW_REG: begin
					drain();
					write_reg(directed[i].sel, directed[i].val[15:0]);
				end
				ROW_QUIET: send_item(directed[i].act, directed[i].idx, directed[i].val, 1'b0);
				default:   send_item(directed[i].act, directed[i].idx, directed[i].val, 1'b1);
			endcase
		end

		// random phases, each with its own register setting
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			divv = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(5, 65535))
				: 16'($urandom_range(0, 4));
			cnt = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(9, 15))
				: 16'($urandom_range(0, 8));
			write_reg(REG_SEND_DIVIDER, divv);
			write_reg(REG_CHANNEL_COUNT, cnt);
			write_reg(REG_START_BYTE_FIRST, 16'($urandom_range(0, 255)));
			write_reg(REG_START_BYTE_SECOND, 16'($urandom_range(0, 255)));
			no_gaps = (ph == 1) || ($urandom_range(0, 4) == 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// sender holds off until the pending frame is fully out
				if (ph == 3 && k == PHASE_ITEMS / 2) drain();
				act = ($urandom_range(0, 1) == 1) ? ACT_TICK : ACT_STORE;
				idx = 3'($urandom_range(0, 7));
				case ($urandom_range(0, 7))
					0:       smp = 32'h0000_0000;
					1:       smp = 32'hFFFF_FFFF;
					default: smp = $urandom;
				endcase
				send_item(act, idx, smp, 1'b1);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (byte_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// receiver stalls
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare each accepted byte with the oldest one queued
	always @(posedge clk) begin
		frame_byte_t want;
		if (out_valid && out_ready) begin
			if (frame_bytes_due.size() == 0) begin
				byte_errors++;
				if (byte_errors <= 10)
					$display("byte %0d: %h last %b with no frame pending",
						bytes_seen, frame_byte, last_byte);
			end else begin
				want = frame_bytes_due.pop_front();
				if (frame_byte !== want.data || last_byte !== want.last) begin
					byte_errors++;
					if (byte_errors <= 10)
						$display("byte %0d: expected %h last %b, got %h last %b",
							bytes_seen, want.data, want.last, frame_byte, last_byte);
				end
			end
			bytes_seen++;
		end
	end

	// watchdog on cycles with no item moving on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

[filelist.f]
design/tfb_pkg.sv
design/telemetry_frame_builder_crc16_top.sv
dv/telemetry_frame_builder_crc16_top_test.sv
